@@ rtl/exp_golomb_nal_bit_writer_core_assert.svh @@
// Assertion helpers used by the writer core back end
`ifndef EXP_GOLOMB_NAL_BIT_WRITER_CORE_ASSERT_SVH
`define EXP_GOLOMB_NAL_BIT_WRITER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define EGNBW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define EGNBW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/egnbw_pkg.sv @@
package egnbw_pkg;

   // Widths fixed by the external interface
   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int LIMIT_W            = 16;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;

   // Command codes
   localparam logic [1:0] CMD_FIXED  = 2'd0;
   localparam logic [1:0] CMD_UE     = 2'd1;
   localparam logic [1:0] CMD_SE     = 2'd2;
   localparam logic [1:0] CMD_FINISH = 2'd3;

   // Register index of the byte limit
   localparam logic REG_LIMIT = 1'b0;

   localparam logic [7:0] ESC_BYTE = 8'h03;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] value;
      logic [5:0]  bit_count;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_escape;
      logic       last;
      logic       end_of_unit;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Longest code: lead zeros, a one and lead info bits
   function automatic int stream_width(input int vb);
      return 2 * vb + 1;
   endfunction

   function automatic int len_width(input int vb);
      return $clog2(2 * vb + 2);
   endfunction

   // Token: finish flag, bit length, left-aligned bits
   function automatic int tok_width(input int vb);
      return 1 + len_width(vb) + stream_width(vb);
   endfunction

endpackage

@@ rtl/egnbw_front.sv @@
module egnbw_front #(
   parameter int VALUE_BITS = egnbw_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_valid,
   output logic                                            req_stall,
   input  egnbw_pkg::req_type                              req_payload,
   input  egnbw_pkg::queue_status_type                     q_status,
   output logic                                            tok_push,
   output logic [egnbw_pkg::tok_width(VALUE_BITS)-1:0]     tok_data
);
   import egnbw_pkg::*;

   localparam int CP_W     = VALUE_BITS + 1;
   localparam int STREAM_W = stream_width(VALUE_BITS);
   localparam int LEN_W    = len_width(VALUE_BITS);
   localparam int NCHUNK   = (CP_W + 7) / 8;
   localparam int PAD_W    = NCHUNK * 8;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_LOD  = 4'b0010,
      F_LEAD = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type   state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [CP_W-1:0]   pay_ff, pay_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [NCHUNK-1:0] nz_ff, nz_in;
   logic [2:0]        pos_ff [NCHUNK];
   logic [2:0]        pos_in [NCHUNK];

   logic [VALUE_BITS-1:0] in_val;
   logic [VALUE_BITS-1:0] in_neg;
   logic [CP_W-1:0]       in_code;
   logic [5:0]            in_count;
   logic [PAD_W-1:0]      pad;
   logic [LEN_W-1:0]      len_lead;
   logic [LEN_W-1:0]      shift_amt;
   logic [STREAM_W-1:0]   stream;

   // Work out the payload word of an arriving request: the field itself or the code plus one
   always_comb begin
      in_val = req_payload.value[VALUE_BITS-1:0];
      in_neg = ~in_val + VALUE_BITS'(1);
      if (req_payload.bit_count > 6'(VALUE_BITS)) begin
         in_count = 6'(VALUE_BITS);
      end else begin
         in_count = req_payload.bit_count;
      end
      unique case (req_payload.cmd)
         CMD_FIXED: begin
            in_code = {1'b0, in_val};
         end
         CMD_UE: begin
            in_code = {1'b0, in_val} + CP_W'(1);
         end
         CMD_SE: begin
            if (in_val[VALUE_BITS-1]) begin
               in_code = {in_neg, 1'b1};
            end else if (in_val == '0) begin
               in_code = CP_W'(1);
            end else begin
               in_code = {in_val, 1'b0};
            end
         end
         CMD_FINISH: begin
            in_code = CP_W'(1);
         end
      endcase
   end

   // Find the leading one inside each byte-wide chunk
   always_comb begin
      pad = PAD_W'(pay_ff);
      for (int c = 0; c < NCHUNK; c++) begin
         nz_in[c]  = |pad[c*8 +: 8];
         pos_in[c] = 3'd0;
         for (int j = 0; j < 8; j++) begin
            if (pad[c*8 + j]) begin
               pos_in[c] = 3'(j);
            end
         end
      end
   end

   // Pick the highest busy chunk; code length is twice the leading-one place plus one
   always_comb begin
      len_lead = LEN_W'(1);
      for (int c = 0; c < NCHUNK; c++) begin
         if (nz_ff[c]) begin
            len_lead = LEN_W'(16 * c) + LEN_W'({pos_ff[c], 1'b1});
         end
      end
   end

   // Left-align the code so the back end takes bits from the top
   always_comb begin
      shift_amt = LEN_W'(STREAM_W) - len_ff;
      stream    = STREAM_W'(pay_ff) << shift_amt;
   end

   assign req_stall = (state_ff != F_IDLE);
   assign tok_push  = (state_ff == F_PUSH) && !q_status.full;
   assign tok_data  = {(cmd_ff == CMD_FINISH), len_ff, stream};

   // Sequence one request: accept, chunk search, length, hand over; fixed puts and finish skip search and length
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      pay_in   = pay_ff;
      len_in   = len_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               cmd_in = req_payload.cmd;
               pay_in = in_code;
               if (req_payload.cmd == CMD_FIXED) begin
                  len_in = LEN_W'(in_count);
               end else begin
                  len_in = LEN_W'(1);
               end
               if (req_payload.cmd == CMD_UE || req_payload.cmd == CMD_SE) begin
                  state_in = F_LOD;
               end else begin
                  state_in = F_PUSH;
               end
            end
         end
         F_LOD: begin
            state_in = F_LEAD;
         end
         F_LEAD: begin
            len_in   = len_lead;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_status.full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Payload registers hold without reset
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      pay_ff <= pay_in;
      len_ff <= len_in;
      nz_ff  <= nz_in;
      pos_ff <= pos_in;
   end

endmodule

@@ rtl/egnbw_queue.sv @@
module egnbw_queue #(
   parameter int WIDTH = egnbw_pkg::tok_width(egnbw_pkg::DEFAULT_VALUE_BITS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            push_data,
   input  logic                        pop,
   output logic [WIDTH-1:0]            pop_data,
   output egnbw_pkg::queue_status_type status
);
   import egnbw_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming token
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/egnbw_back.sv @@
`include "exp_golomb_nal_bit_writer_core_assert.svh"

module egnbw_back #(
   parameter int VALUE_BITS = egnbw_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [egnbw_pkg::LIMIT_W-1:0]               limit,
   input  logic [egnbw_pkg::tok_width(VALUE_BITS)-1:0] tok_data,
   input  egnbw_pkg::queue_status_type                 q_status,
   output logic                                        tok_pop,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output egnbw_pkg::rsp_type                          rsp_payload
);
   import egnbw_pkg::*;

   localparam int STREAM_W = stream_width(VALUE_BITS);
   localparam int LEN_W    = len_width(VALUE_BITS);
   localparam int TOK_W    = tok_width(VALUE_BITS);
   localparam int ACC_W    = STREAM_W + 7;
   localparam int TOT_W    = $clog2(ACC_W + 1);

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_BYTE = 2'b10
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic               fin_ff, fin_in;
   logic               esc_done_ff, esc_done_in;
   logic [7:0]         partial_ff, partial_in;
   logic [2:0]         bits_used_ff, bits_used_in;
   logic [1:0]         zero_run_ff, zero_run_in;
   logic [LIMIT_W-1:0] bytes_ff, bytes_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic                tok_fin;
   logic [LEN_W-1:0]    tok_len;
   logic [STREAM_W-1:0] tok_bits;
   logic [ACC_W-1:0]    load_acc;
   logic [TOT_W-1:0]    sum_total;
   logic [TOT_W-1:0]    load_total;
   logic [7:0]          cur_byte;
   logic                room;
   logic                full_after;
   logic                need_esc;
   logic                final_byte;
   logic                emit_data;
   logic                emit_marker;
   logic                out_free;
   logic                step_data;

   // Unpack the token and merge it under the partial byte
   always_comb begin
      tok_fin    = tok_data[TOK_W-1];
      tok_len    = tok_data[STREAM_W +: LEN_W];
      tok_bits   = tok_data[STREAM_W-1:0];
      load_acc   = {partial_ff, {(ACC_W - 8){1'b0}}} | ({tok_bits, 7'b0} >> bits_used_ff);
      sum_total  = TOT_W'(bits_used_ff) + TOT_W'(tok_len);
      load_total = tok_fin ? TOT_W'(8) : sum_total;
   end

   // Classify the byte at the head of the accumulator
   always_comb begin
      cur_byte    = acc_ff[ACC_W-1 -: 8];
      room        = (bytes_ff < limit);
      full_after  = ({1'b0, bytes_ff} + 17'd1) >= {1'b0, limit};
      need_esc    = zero_run_ff[1] && (cur_byte <= ESC_BYTE) && !esc_done_ff;
      final_byte  = (total_ff < TOT_W'(16));
      emit_data   = room;
      emit_marker = !room && fin_ff;
      out_free    = !rsp_valid_ff || !rsp_stall;
      step_data   = (state_ff == B_BYTE) && !need_esc &&
                    (!(emit_data || emit_marker) || out_free);
   end

   // Take a token when idle; emit one escape or data byte per cycle, waiting while a stalled result blocks it
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      fin_in       = fin_ff;
      esc_done_in  = esc_done_ff;
      partial_in   = partial_ff;
      bits_used_in = bits_used_ff;
      zero_run_in  = zero_run_ff;
      bytes_in     = bytes_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      tok_pop      = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               tok_pop = 1'b1;
               if (tok_fin || sum_total >= TOT_W'(8)) begin
                  state_in    = B_BYTE;
                  acc_in      = load_acc;
                  total_in    = load_total;
                  fin_in      = tok_fin;
                  esc_done_in = 1'b0;
               end else begin
                  partial_in   = load_acc[ACC_W-1 -: 8];
                  bits_used_in = sum_total[2:0];
               end
            end
         end
         B_BYTE: begin
            if (need_esc) begin
               if (!room) begin
                  ovf_in      = 1'b1;
                  esc_done_in = 1'b1;
                  zero_run_in = 2'd0;
               end else if (out_free) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.out_byte    = ESC_BYTE;
                  rsp_in.is_escape   = 1'b1;
                  rsp_in.last        = !fin_ff && full_after;
                  rsp_in.end_of_unit = 1'b0;
                  rsp_in.overflow    = ovf_ff;
                  bytes_in           = bytes_ff + LIMIT_W'(1);
                  esc_done_in        = 1'b1;
                  zero_run_in        = 2'd0;
               end
            end else if (step_data) begin
               if (emit_data) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.out_byte    = cur_byte;
                  rsp_in.is_escape   = 1'b0;
                  rsp_in.last        = final_byte || (!fin_ff && full_after);
                  rsp_in.end_of_unit = fin_ff;
                  rsp_in.overflow    = ovf_ff;
                  bytes_in           = bytes_ff + LIMIT_W'(1);
               end else if (emit_marker) begin
                  // final byte of the unit dropped: send the empty closing marker
                  rsp_valid_in       = 1'b1;
                  rsp_in.out_byte    = 8'd0;
                  rsp_in.is_escape   = 1'b0;
                  rsp_in.last        = 1'b1;
                  rsp_in.end_of_unit = 1'b1;
                  rsp_in.overflow    = 1'b1;
               end
               if (!room) begin
                  ovf_in = 1'b1;
               end
               if (cur_byte == 8'd0) begin
                  zero_run_in = zero_run_ff[1] ? 2'd2 : zero_run_ff + 2'd1;
               end else begin
                  zero_run_in = 2'd0;
               end
               acc_in      = acc_ff << 8;
               total_in    = total_ff - TOT_W'(8);
               esc_done_in = 1'b0;
               if (final_byte) begin
                  state_in = B_IDLE;
                  if (fin_ff) begin
                     partial_in   = 8'd0;
                     bits_used_in = 3'd0;
                     zero_run_in  = 2'd0;
                     bytes_in     = '0;
                     ovf_in       = 1'b0;
                  end else begin
                     partial_in   = acc_ff[ACC_W-9 -: 8];
                     bits_used_in = total_ff[2:0];
                  end
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         partial_ff   <= 8'd0;
         bits_used_ff <= 3'd0;
         zero_run_ff  <= 2'd0;
         bytes_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         esc_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         partial_ff   <= partial_in;
         bits_used_ff <= bits_used_in;
         zero_run_ff  <= zero_run_in;
         bytes_ff     <= bytes_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         esc_done_ff  <= esc_done_in;
      end
   end

   // Payload registers hold without reset
   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      total_ff <= total_in;
      fin_ff   <= fin_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `EGNBW_ASSERT_IMPLY(byte_state_has_byte, clock, reset, state_ff == B_BYTE,
      total_ff >= TOT_W'(8), "byte state entered without a whole byte")
   `EGNBW_ASSERT_NEXT(finish_clears_unit, clock, reset, step_data && fin_ff,
      bits_used_ff == 3'd0 && bytes_ff == '0 && !ovf_ff && zero_run_ff == 2'd0,
      "unit state not cleared after finish")
   `EGNBW_ASSERT_IMPLY(escape_is_plain, clock, reset, rsp_valid_ff && rsp_ff.is_escape,
      rsp_ff.out_byte == ESC_BYTE && !rsp_ff.end_of_unit, "malformed escape result")

endmodule

@@ rtl/exp_golomb_nal_bit_writer_core.sv @@
// Channel   | Ports                                   | Moves
// ----------+-----------------------------------------+------------------------------------
// request   | req_valid, req_stall, req_payload       | one command: cmd, value, bit_count
// result    | rsp_valid, rsp_stall, rsp_payload       | one escaped byte with its flags
// control   | csr_psel/penable/pwrite/paddr/pwdata... | byte limit register at offset 0
//
// Front end: a ue/se request goes through accept, chunk search, length and hand over, a fixed put
// or finish through accept and hand over; req_stall holds new requests until hand over is done.
// Back end: takes a token, then sends its data bytes and any escape bytes one at a time.
// A two-entry token queue lets the front run ahead while the back end drains bytes.
// Synchronous reset clears all unit state and sets the byte limit to 256.
// A stalled result is held in the output register; the back end waits only when
// it has a new result for that register.
module exp_golomb_nal_bit_writer_core #(
   parameter int VALUE_BITS = egnbw_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  egnbw_pkg::req_type                  req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output egnbw_pkg::rsp_type                  rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [egnbw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [egnbw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [egnbw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import egnbw_pkg::*;

   localparam int TOK_W = tok_width(VALUE_BITS);

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               reg_sel;
   logic               csr_write;
   logic               tok_push;
   logic               tok_pop;
   logic [TOK_W-1:0]   push_tok;
   logic [TOK_W-1:0]   pop_tok;
   queue_status_type   q_status;

   // Decode the register window and take writes in the access phase
   always_comb begin
      reg_sel   = (csr_paddr[CSR_ADDR_W-1] == REG_LIMIT);
      csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
      limit_in  = limit_ff;
      if (csr_write && reg_sel) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? CSR_DATA_W'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   egnbw_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .tok_push    (tok_push),
      .tok_data    (push_tok)
   );

   egnbw_queue #(
      .WIDTH (TOK_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_push),
      .push_data (push_tok),
      .pop       (tok_pop),
      .pop_data  (pop_tok),
      .status    (q_status)
   );

   egnbw_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .limit       (limit_ff),
      .tok_data    (pop_tok),
      .q_status    (q_status),
      .tok_pop     (tok_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
